>>> design/ucrd_pkg.sv
`default_nettype none

package ucrd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned LEN_W       = 10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEV_DESC_LEN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONF_TOTAL_LEN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LANG_DESC_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_DESC_LEN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MFR_CHARS       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROD_CHARS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERIAL_CHARS    = 3'd6;

    // bmRequestType type field and recipient
    localparam logic [1:0] REQ_TYPE_STANDARD = 2'd0;
    localparam logic [1:0] REQ_TYPE_CLASS    = 2'd1;
    localparam logic [4:0] RECIP_ENDPOINT    = 5'd2;

    // bRequest codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_ASSIGN_ADDR       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_HID_READ_REPORT   = 8'd1;

    // Descriptor types (wValue high byte)
    localparam logic [7:0] DESC_DEVICE     = 8'h01;
    localparam logic [7:0] DESC_CONFIG     = 8'h02;
    localparam logic [7:0] DESC_STRING     = 8'h03;
    localparam logic [7:0] DESC_HID_REPORT = 8'h22;

    // String indexes (wValue low byte)
    localparam logic [7:0] STR_LANGUAGE     = 8'd0;
    localparam logic [7:0] STR_MANUFACTURER = 8'd1;
    localparam logic [7:0] STR_PRODUCT      = 8'd2;
    localparam logic [7:0] STR_SERIAL       = 8'd3;

    // HID report types
    localparam logic [7:0] REPORT_INPUT   = 8'd1;
    localparam logic [7:0] REPORT_OUTPUT  = 8'd2;
    localparam logic [7:0] REPORT_FEATURE = 8'd3;

    localparam logic [LEN_W-1:0] STATUS_WORD_LEN = 10'd2;

    typedef enum logic [1:0] {
        REPLY_STALL = 2'd0,
        REPLY_ACK   = 2'd1,
        REPLY_DATA  = 2'd2,
        REPLY_NONE  = 2'd3
    } reply_kind_e;

    typedef enum logic [2:0] {
        DSRC_DEVICE       = 3'd0,
        DSRC_CONFIG       = 3'd1,
        DSRC_LANGUAGE     = 3'd2,
        DSRC_MANUFACTURER = 3'd3,
        DSRC_PRODUCT      = 3'd4,
        DSRC_SERIAL       = 3'd5,
        DSRC_REPORT       = 3'd6,
        DSRC_STATUS       = 3'd7
    } data_src_e;

    typedef enum logic [2:0] {
        DEV_ATTACHED   = 3'd0,
        DEV_POWERED    = 3'd1,
        DEV_DEFAULT    = 3'd2,
        DEV_ADDRESSED  = 3'd3,
        DEV_CONFIGURED = 3'd4
    } dev_state_e;

    typedef struct packed {
        logic [7:0]  request_kind;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } setup_t;

    typedef struct packed {
        logic [1:0]       reply_kind;
        logic [2:0]       data_source;
        logic [LEN_W-1:0] reply_length;
        logic             status_halted;
        logic [6:0]       device_address_out;
        logic [2:0]       device_state_out;
        logic             endpoint_halted;
    } reply_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } cfg_write_t;

    typedef struct packed {
        logic [7:0]       dev_desc_len;
        logic [LEN_W-1:0] conf_total_len;
        logic [7:0]       lang_desc_len;
        logic [7:0]       report_desc_len;
        logic [6:0]       mfr_chars;
        logic [6:0]       prod_chars;
        logic [6:0]       serial_chars;
    } cfg_regs_t;

    typedef struct packed {
        logic       halt;
        logic [6:0] address;
        dev_state_e state;
    } dev_ctx_t;

    // Data stage length: the smaller of wLength and what the device has.
    function automatic logic [LEN_W-1:0] clamp_len(logic [15:0] want, logic [LEN_W-1:0] have);
        logic [15:0] have_ext;
        have_ext = {{(16-LEN_W){1'b0}}, have};
        return (want > have_ext) ? have : want[LEN_W-1:0];
    endfunction

    // String descriptor bytes: two per character plus the two-byte header.
    function automatic logic [LEN_W-1:0] str_len(logic [6:0] chars);
        return {2'b00, chars, 1'b0} + 10'd2;
    endfunction

endpackage

`default_nettype wire

>>> design/ucrd_ifs.sv
`default_nettype none

interface ucrd_setup_if;
    import ucrd_pkg::*;
    logic   valid;
    logic   ready;
    setup_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ucrd_reply_if;
    import ucrd_pkg::*;
    logic   valid;
    logic   ready;
    reply_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ucrd_cfg_if;
    import ucrd_pkg::*;
    logic       valid;
    logic       ready;
    cfg_write_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/ucrd_decode.sv
`default_nettype none

module ucrd_decode (
    input  ucrd_pkg::setup_t    req,
    input  ucrd_pkg::cfg_regs_t cfg_regs,
    input  ucrd_pkg::dev_ctx_t  ctx,
    output ucrd_pkg::reply_t    result,
    output ucrd_pkg::dev_ctx_t  ctx_next
);
    import ucrd_pkg::*;

    logic [1:0]       req_type;
    logic [4:0]       recip;
    logic [7:0]       vhi;
    logic [7:0]       vlo;
    reply_kind_e      kind;
    data_src_e        src;
    logic [LEN_W-1:0] len;
    logic             shalt;

    assign req_type = req.request_kind[6:5];
    assign recip    = req.request_kind[4:0];
    assign vhi      = req.request_value[15:8];
    assign vlo      = req.request_value[7:0];

    always_comb
    begin
        kind     = REPLY_STALL;
        src      = DSRC_DEVICE;
        len      = '0;
        shalt    = 1'b0;
        ctx_next = ctx;
        case (req_type)
            REQ_TYPE_STANDARD:
            begin
                unique case (req.request_code) inside
                    REQ_GET_STATUS:
                    begin
                        kind  = REPLY_DATA;
                        src   = DSRC_STATUS;
                        len   = STATUS_WORD_LEN;
                        shalt = (recip == RECIP_ENDPOINT) ? ctx.halt : 1'b0;
                    end
                    REQ_CLEAR_FEATURE, REQ_SET_FEATURE:
                    begin
                        if (recip == RECIP_ENDPOINT)
                        begin
                            ctx_next.halt = (req.request_code == REQ_SET_FEATURE);
                            kind          = REPLY_ACK;
                        end
                    end
                    REQ_ASSIGN_ADDR:
                    begin
                        ctx_next.address = req.request_value[6:0];
                        ctx_next.state   = DEV_ADDRESSED;
                        kind             = REPLY_ACK;
                    end
                    REQ_GET_DESCRIPTOR:
                    begin
                        unique case (vhi)
                            DESC_DEVICE:
                            begin
                                kind = REPLY_DATA;
                                src  = DSRC_DEVICE;
                                len  = clamp_len(req.request_length,
                                                 {2'b00, cfg_regs.dev_desc_len});
                            end
                            DESC_CONFIG:
                            begin
                                kind = REPLY_DATA;
                                src  = DSRC_CONFIG;
                                len  = clamp_len(req.request_length, cfg_regs.conf_total_len);
                            end
                            DESC_STRING:
                            begin
                                unique case (vlo)
                                    STR_LANGUAGE:
                                    begin
                                        kind = REPLY_DATA;
                                        src  = DSRC_LANGUAGE;
                                        len  = clamp_len(req.request_length,
                                                         {2'b00, cfg_regs.lang_desc_len});
                                    end
                                    STR_MANUFACTURER:
                                    begin
                                        kind = REPLY_DATA;
                                        src  = DSRC_MANUFACTURER;
                                        len  = str_len(cfg_regs.mfr_chars);
                                    end
                                    STR_PRODUCT:
                                    begin
                                        kind = REPLY_DATA;
                                        src  = DSRC_PRODUCT;
                                        len  = str_len(cfg_regs.prod_chars);
                                    end
                                    STR_SERIAL:
                                    begin
                                        kind = REPLY_DATA;
                                        src  = DSRC_SERIAL;
                                        len  = str_len(cfg_regs.serial_chars);
                                    end
                                    default: ;
                                endcase
                            end
                            DESC_HID_REPORT:
                            begin
                                kind = REPLY_DATA;
                                src  = DSRC_REPORT;
                                len  = clamp_len(req.request_length,
                                                 {2'b00, cfg_regs.report_desc_len});
                            end
                            default: ;
                        endcase
                    end
                    REQ_SET_CONFIGURATION:
                    begin
                        ctx_next.state = DEV_CONFIGURED;
                        kind           = REPLY_ACK;
                    end
                    default: ;
                endcase
            end
            REQ_TYPE_CLASS:
            begin
                if (req.request_code == REQ_HID_READ_REPORT)
                begin
                    if (vhi == REPORT_INPUT)
                    begin
                        kind = REPLY_DATA;
                        src  = DSRC_REPORT;
                        len  = clamp_len(req.request_length, {2'b00, cfg_regs.report_desc_len});
                    end
                    else if (vhi == REPORT_OUTPUT || vhi == REPORT_FEATURE)
                    begin
                        kind = REPLY_STALL;
                    end
                    else
                    begin
                        kind = REPLY_NONE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.reply_kind         = kind;
        result.data_source        = src;
        result.reply_length       = len;
        result.status_halted      = shalt;
        result.device_address_out = ctx_next.address;
        result.device_state_out   = ctx_next.state;
        result.endpoint_halted    = ctx_next.halt;
    end

endmodule

`default_nettype wire

>>> design/usb_control_request_decoder.sv
// Endpoint-0 setup request decoder.
//
// setup : setup packet in (bmRequestType, bRequest, wValue, wIndex, wLength).
// reply : one result transaction per setup transaction: reply kind (stall,
//         zero-length ack, data stage, no change), data source, byte count,
//         status word bit, and the device address/state/halt flag after the
//         request took effect.
// cfg   : register writes (descriptor lengths, string character counts);
//         always ready. User must write only while no setup transaction is in flight; not enforced.
//
// A setup transaction is registered in the input register and decoded from it;
// its result is registered in the result register once that register is free.
// Throughput is one transaction per cycle while the receiver keeps reply.ready
// high: the input register and the result register form a two-entry pipeline;
// while a result waits, one more setup is still taken into the input register.
// When the receiver stalls, the result register holds and the input register
// fills; setup.ready drops only once both are occupied.
// Reset clears both valid flags, sets the descriptor lengths to their defaults
// (18, 34, 4, 52, string counts zero), the halt flag and address to zero and
// the device state to default.
`default_nettype none

module usb_control_request_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ucrd_setup_if.sink  setup,
    ucrd_reply_if.source reply,
    ucrd_cfg_if.sink    cfg
);
    import ucrd_pkg::*;

    logic      s1_valid_reg;
    setup_t    s1_data_reg;
    logic      out_valid_reg;
    reply_t    out_data_reg;
    cfg_regs_t cfg_reg;
    dev_ctx_t  ctx_reg;
    dev_ctx_t  ctx_next;
    reply_t    dec_reply;
    logic      out_free;
    logic      s1_fire;
    logic      setup_accept;

    // Pipeline control
    assign out_free     = !out_valid_reg || reply.ready;
    assign s1_fire      = s1_valid_reg && out_free;
    assign setup.ready  = !s1_valid_reg || out_free;
    assign setup_accept = setup.valid && setup.ready;

    assign reply.valid = out_valid_reg;
    assign reply.data  = out_data_reg;
    assign cfg.ready   = 1'b1;

    ucrd_decode u_decode (
        .req      (s1_data_reg),
        .cfg_regs (cfg_reg),
        .ctx      (ctx_reg),
        .result   (dec_reply),
        .ctx_next (ctx_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (setup.ready)
                s1_valid_reg <= setup.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (setup_accept)
            s1_data_reg <= setup.data;
        if (s1_fire)
            out_data_reg <= dec_reply;
    end

    // Device state advances with each decoded request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.halt    <= 1'b0;
            ctx_reg.address <= '0;
            ctx_reg.state   <= DEV_DEFAULT;
        end
        else if (s1_fire)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Configuration registers, masked to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_desc_len    <= 8'd18;
            cfg_reg.conf_total_len  <= 10'd34;
            cfg_reg.lang_desc_len   <= 8'd4;
            cfg_reg.report_desc_len <= 8'd52;
            cfg_reg.mfr_chars       <= '0;
            cfg_reg.prod_chars      <= '0;
            cfg_reg.serial_chars    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_DEV_DESC_LEN:    cfg_reg.dev_desc_len    <= cfg.data.value[7:0];
                CFG_CONF_TOTAL_LEN:  cfg_reg.conf_total_len  <= cfg.data.value;
                CFG_LANG_DESC_LEN:   cfg_reg.lang_desc_len   <= cfg.data.value[7:0];
                CFG_REPORT_DESC_LEN: cfg_reg.report_desc_len <= cfg.data.value[7:0];
                CFG_MFR_CHARS:       cfg_reg.mfr_chars       <= cfg.data.value[6:0];
                CFG_PROD_CHARS:      cfg_reg.prod_chars      <= cfg.data.value[6:0];
                CFG_SERIAL_CHARS:    cfg_reg.serial_chars    <= cfg.data.value[6:0];
                default: ;
            endcase
        end
    end

    // A standard address assignment leaving the input stage lands in the state register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_data_reg.request_kind[6:5] == REQ_TYPE_STANDARD
            && s1_data_reg.request_code == REQ_ASSIGN_ADDR
        |=> ctx_reg.state == DEV_ADDRESSED
            && ctx_reg.address == $past(s1_data_reg.request_value[6:0]))
    else $error("address assignment not applied to device state");

    // Non-data replies carry no source, length or status bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.reply_kind != REPLY_DATA
        |-> out_data_reg.data_source == DSRC_DEVICE && out_data_reg.reply_length == '0
            && !out_data_reg.status_halted)
    else $error("non-data reply with data fields set");

    // Status bit only on a two-byte status word data stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status_halted
        |-> out_data_reg.reply_kind == REPLY_DATA && out_data_reg.data_source == DSRC_STATUS
            && out_data_reg.reply_length == STATUS_WORD_LEN)
    else $error("status bit outside a status data stage");

    // Result reflects the halt flag and device state that the state register took with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_data_reg.endpoint_halted == ctx_reg.halt
            && out_data_reg.device_state_out == ctx_reg.state)
    else $error("result state fields differ from device state");

endmodule

`default_nettype wire

>>> tb/ucrd_reply_checker.sv
`timescale 1ns / 100ps

module ucrd_reply_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    ucrd_setup_if     setup_bus,
    ucrd_reply_if     reply_bus,
    ucrd_cfg_if       cfg_bus,
    output int        error_count,
    output int        pending_count
);
    import ucrd_pkg::*;

    // Model copy of the registers and device state
    cfg_regs_t  desc_regs;
    logic       ep_halt;
    logic [6:0] dev_addr;
    dev_state_e dev_state;

    reply_t     pending_replies[$];
    reply_t     got;
    reply_t     want;
    int         mismatches;

    // Host asks for at most 'asked' bytes; full 16-bit compare.
    function automatic logic [LEN_W-1:0] fit_length(logic [15:0] asked,
                                                    logic [LEN_W-1:0] avail);
        if (int'(asked) > int'(avail))
            return avail;
        else
            return asked[LEN_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] string_bytes(logic [6:0] chars);
        return LEN_W'(2 * int'(chars) + 2);
    endfunction

    // Decode one setup transaction, update device state, return the reply.
    function automatic reply_t decode_setup(setup_t s);
        logic [1:0] req_type;
        logic [4:0] recip;
        logic [7:0] desc_type;
        logic [7:0] desc_idx;
        reply_t     r;
        req_type  = s.request_kind[6:5];
        recip     = s.request_kind[4:0];
        desc_type = s.request_value[15:8];
        desc_idx  = s.request_value[7:0];
        r = '0;
        r.reply_kind = REPLY_STALL;
        if (req_type == REQ_TYPE_STANDARD)
        begin
            case (s.request_code)
                REQ_GET_STATUS:
                begin
                    r.reply_kind    = REPLY_DATA;
                    r.data_source   = DSRC_STATUS;
                    r.reply_length  = LEN_W'(2);
                    r.status_halted = (recip == RECIP_ENDPOINT) && ep_halt;
                end
                REQ_CLEAR_FEATURE, REQ_SET_FEATURE:
                begin
                    if (recip == RECIP_ENDPOINT)
                    begin
                        ep_halt      = (s.request_code == REQ_SET_FEATURE);
                        r.reply_kind = REPLY_ACK;
                    end
                end
                REQ_ASSIGN_ADDR:
                begin
                    dev_addr     = s.request_value[6:0];
                    dev_state    = DEV_ADDRESSED;
                    r.reply_kind = REPLY_ACK;
                end
                REQ_GET_DESCRIPTOR:
                begin
                    r.reply_kind = REPLY_DATA;
                    case (desc_type)
                        DESC_DEVICE:
                        begin
                            r.data_source  = DSRC_DEVICE;
                            r.reply_length = fit_length(s.request_length,
                                                        LEN_W'(desc_regs.dev_desc_len));
                        end
                        DESC_CONFIG:
                        begin
                            r.data_source  = DSRC_CONFIG;
                            r.reply_length = fit_length(s.request_length,
                                                        desc_regs.conf_total_len);
                        end
                        DESC_STRING:
                        begin
                            case (desc_idx)
                                STR_LANGUAGE:
                                begin
                                    r.data_source  = DSRC_LANGUAGE;
                                    r.reply_length = fit_length(s.request_length,
                                                         LEN_W'(desc_regs.lang_desc_len));
                                end
                                STR_MANUFACTURER:
                                begin
                                    r.data_source  = DSRC_MANUFACTURER;
                                    r.reply_length = string_bytes(desc_regs.mfr_chars);
                                end
                                STR_PRODUCT:
                                begin
                                    r.data_source  = DSRC_PRODUCT;
                                    r.reply_length = string_bytes(desc_regs.prod_chars);
                                end
                                STR_SERIAL:
                                begin
                                    r.data_source  = DSRC_SERIAL;
                                    r.reply_length = string_bytes(desc_regs.serial_chars);
                                end
                                default: r.reply_kind = REPLY_STALL;
                            endcase
                        end
                        DESC_HID_REPORT:
                        begin
                            r.data_source  = DSRC_REPORT;
                            r.reply_length = fit_length(s.request_length,
                                                        LEN_W'(desc_regs.report_desc_len));
                        end
                        default: r.reply_kind = REPLY_STALL;
                    endcase
                end
                REQ_SET_CONFIGURATION:
                begin
                    dev_state    = DEV_CONFIGURED;
                    r.reply_kind = REPLY_ACK;
                end
                default: ;
            endcase
        end
        else if (req_type == REQ_TYPE_CLASS && s.request_code == REQ_HID_READ_REPORT)
        begin
            case (desc_type)
                REPORT_INPUT:
                begin
                    r.reply_kind   = REPLY_DATA;
                    r.data_source  = DSRC_REPORT;
                    r.reply_length = fit_length(s.request_length,
                                                LEN_W'(desc_regs.report_desc_len));
                end
                REPORT_OUTPUT, REPORT_FEATURE: r.reply_kind = REPLY_STALL;
                default: r.reply_kind = REPLY_NONE;
            endcase
        end
        r.device_address_out = dev_addr;
        r.device_state_out   = dev_state;
        r.endpoint_halted    = ep_halt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_regs = '{dev_desc_len: 8'd18, conf_total_len: 10'd34,
                          lang_desc_len: 8'd4, report_desc_len: 8'd52,
                          mfr_chars: 7'd0, prod_chars: 7'd0, serial_chars: 7'd0};
            ep_halt    = 1'b0;
            dev_addr   = '0;
            dev_state  = DEV_DEFAULT;
            mismatches = 0;
            pending_replies.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.data.index)
                    CFG_DEV_DESC_LEN:    desc_regs.dev_desc_len    = cfg_bus.data.value[7:0];
                    CFG_CONF_TOTAL_LEN:  desc_regs.conf_total_len  = cfg_bus.data.value;
                    CFG_LANG_DESC_LEN:   desc_regs.lang_desc_len   = cfg_bus.data.value[7:0];
                    CFG_REPORT_DESC_LEN: desc_regs.report_desc_len = cfg_bus.data.value[7:0];
                    CFG_MFR_CHARS:       desc_regs.mfr_chars       = cfg_bus.data.value[6:0];
                    CFG_PROD_CHARS:      desc_regs.prod_chars      = cfg_bus.data.value[6:0];
                    CFG_SERIAL_CHARS:    desc_regs.serial_chars    = cfg_bus.data.value[6:0];
                    default: ;
                endcase
            end

            if (reply_bus.valid && reply_bus.ready)
            begin
                got = reply_bus.data;
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply transaction with none pending: %h", $realtime, got);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.reply_kind !== want.reply_kind ||
                        got.data_source !== want.data_source ||
                        got.reply_length !== want.reply_length ||
                        got.status_halted !== want.status_halted ||
                        got.device_address_out !== want.device_address_out ||
                        got.device_state_out !== want.device_state_out ||
                        got.endpoint_halted !== want.endpoint_halted)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: reply mismatch: exp kind=%0d src=%0d len=%0d ",
                                      "stat=%0b addr=%0d st=%0d halt=%0b | got kind=%0d ",
                                      "src=%0d len=%0d stat=%0b addr=%0d st=%0d halt=%0b"},
                                     $realtime, want.reply_kind, want.data_source,
                                     want.reply_length, want.status_halted,
                                     want.device_address_out, want.device_state_out,
                                     want.endpoint_halted, got.reply_kind, got.data_source,
                                     got.reply_length, got.status_halted,
                                     got.device_address_out, got.device_state_out,
                                     got.endpoint_halted);
                    end
                end
            end

            if (setup_bus.valid && setup_bus.ready)
                pending_replies.push_back(decode_setup(setup_bus.data));

            error_count   <= mismatches;
            pending_count <= pending_replies.size();
        end
    end

endmodule

>>> tb/usb_control_request_decoder_tb.sv
`timescale 1ns / 100ps

module usb_control_request_decoder_tb;
    import ucrd_pkg::*;

    // Run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 64;   // long receiver hold-off, fills the pipeline
    localparam int DRAIN_CYCLES = 4;    // result register loads after the input register

    // Codes the package does not name
    localparam logic [4:0] RECIP_DEVICE     = 5'd0;
    localparam logic [4:0] RECIP_INTERFACE  = 5'd1;
    localparam logic [1:0] REQ_TYPE_VENDOR  = 2'd2;
    localparam logic [1:0] REQ_TYPE_RSVD    = 2'd3;
    localparam logic [7:0] REQ_SYNCH_FRAME  = 8'd12;
    localparam logic [7:0] DESC_INTERFACE   = 8'h04;
    localparam logic [7:0] REPORT_RSVD      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    ucrd_setup_if setup_bus ();
    ucrd_reply_if reply_bus ();
    ucrd_cfg_if   cfg_bus ();

    int        error_count;
    int        pending_count;
    int        cycle_count = 0;

    // Idle rates in percent per cycle; the stimulus changes them per phase
    int        send_idle_pct = 9;
    int        recv_idle_pct = 70;
    bit        stall_req     = 1'b0;

    // Register values the block currently holds, used to aim lengths at the clamp edge
    cfg_regs_t live_regs;

    always #4 clk = ~clk;

    usb_control_request_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .setup (setup_bus),
        .reply (reply_bus),
        .cfg   (cfg_bus)
    );

    // Watches all three channels, predicts each reply and compares
    ucrd_reply_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .setup_bus     (setup_bus),
        .reply_bus     (reply_bus),
        .cfg_bus       (cfg_bus),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Watchdog: a hang or a lost reply ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Reply side: random ready, with one long hold-off whenever the stimulus asks.
    // The hold-off is counted here so the sender keeps offering the whole time.
    initial
    begin
        reply_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                reply_bus.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_req = 1'b0;
            end
            reply_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // One setup transaction; random gaps before it per the current idle rate.
    // Returns at the edge where the transaction was accepted.
    task automatic send_setup(input setup_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            setup_bus.valid <= 1'b0;
            @(posedge clk);
        end
        setup_bus.valid <= 1'b1;
        setup_bus.data  <= s;
        @(posedge clk);
        while (!setup_bus.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= '{index: idx, value: val};
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // Write every register; bits above a register's width get random junk,
    // the block must drop them. The spare index must be ignored.
    task automatic program_regs(input cfg_regs_t r);
        write_reg(CFG_DEV_DESC_LEN,    {2'($urandom), r.dev_desc_len});
        write_reg(CFG_CONF_TOTAL_LEN,  r.conf_total_len);
        write_reg(CFG_LANG_DESC_LEN,   {2'($urandom), r.lang_desc_len});
        write_reg(CFG_REPORT_DESC_LEN, {2'($urandom), r.report_desc_len});
        write_reg(CFG_MFR_CHARS,       {3'($urandom), r.mfr_chars});
        write_reg(CFG_PROD_CHARS,      {3'($urandom), r.prod_chars});
        write_reg(CFG_SERIAL_CHARS,    {3'($urandom), r.serial_chars});
        write_reg(CFG_SPARE_INDEX,     10'($urandom));
        cfg_bus.valid <= 1'b0;
        live_regs = r;
    endtask

    // Wait until every predicted reply has come back. The first edge makes
    // sure the checker has seen the last accepted setup transaction.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic setup_t setup_pkt(input logic [7:0] kind, input logic [7:0] code,
                                         input logic [15:0] value, input logic [15:0] length);
        setup_t s;
        s.request_kind   = kind;
        s.request_code   = code;
        s.request_value  = value;
        s.request_index  = 16'($urandom);
        s.request_length = length;
        return s;
    endfunction

    // wLength: small, around the 8-bit and 10-bit boundaries, full range, extremes,
    // and at or next to a register value so the clamp flips.
    function automatic logic [15:0] random_length();
        logic [15:0] near;
        case ($urandom_range(0, 3))
            0:       near = 16'(live_regs.dev_desc_len);
            1:       near = 16'(live_regs.conf_total_len);
            2:       near = 16'(live_regs.lang_desc_len);
            default: near = 16'(live_regs.report_desc_len);
        endcase
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 16));
            1:       return 16'($urandom_range(0, 300));
            2:       return 16'($urandom_range(256, 1100));
            3:       return 16'($urandom);
            4:       return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
            default: return near + 16'($urandom_range(0, 2)) - 16'd1;
        endcase
    endfunction

    // Mostly well-formed requests with random content; the rest is noise.
    function automatic setup_t random_setup();
        setup_t      s;
        int          pick;
        logic        dir;
        logic [4:0]  recip;
        logic [7:0]  dtype;
        logic [7:0]  didx;
        s.request_kind   = 8'($urandom);
        s.request_code   = 8'($urandom);
        s.request_value  = 16'($urandom);
        s.request_index  = 16'($urandom);
        s.request_length = random_length();
        dir   = s.request_kind[7];
        recip = ($urandom_range(0, 1) != 0) ? RECIP_ENDPOINT : s.request_kind[4:0];
        pick  = $urandom_range(0, 99);
        if (pick < 10)
        begin
            s.request_kind = {dir, REQ_TYPE_STANDARD, recip};
            s.request_code = REQ_GET_STATUS;
        end
        else if (pick < 25)
        begin
            if ($urandom_range(0, 4) != 0)
                recip = RECIP_ENDPOINT;
            s.request_kind = {dir, REQ_TYPE_STANDARD, recip};
            s.request_code = ($urandom_range(0, 1) != 0) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
        end
        else if (pick < 33)
        begin
            s.request_kind = {dir, REQ_TYPE_STANDARD, recip};
            s.request_code = REQ_ASSIGN_ADDR;
        end
        else if (pick < 63)
        begin
            case ($urandom_range(0, 5))
                0:       dtype = DESC_DEVICE;
                1:       dtype = DESC_CONFIG;
                2, 3:    dtype = DESC_STRING;
                4:       dtype = DESC_HID_REPORT;
                default: dtype = 8'($urandom);
            endcase
            if ($urandom_range(0, 4) != 0)
                didx = 8'($urandom_range(int'(STR_LANGUAGE), int'(STR_SERIAL) + 1));
            else
                didx = 8'($urandom);
            s.request_kind  = {dir, REQ_TYPE_STANDARD, recip};
            s.request_code  = REQ_GET_DESCRIPTOR;
            s.request_value = {dtype, didx};
        end
        else if (pick < 68)
        begin
            s.request_kind = {dir, REQ_TYPE_STANDARD, recip};
            s.request_code = REQ_SET_CONFIGURATION;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 5))
                0, 1:    dtype = REPORT_INPUT;
                2:       dtype = REPORT_OUTPUT;
                3:       dtype = REPORT_FEATURE;
                4:       dtype = REPORT_RSVD;
                default: dtype = 8'($urandom);
            endcase
            s.request_kind  = {dir, REQ_TYPE_CLASS, recip};
            s.request_code  = REQ_HID_READ_REPORT;
            s.request_value = {dtype, s.request_value[7:0]};
        end
        return s;
    endfunction

    function automatic cfg_regs_t random_regs();
        cfg_regs_t r;
        r.dev_desc_len    = 8'($urandom);
        r.conf_total_len  = 10'($urandom);
        r.lang_desc_len   = 8'($urandom);
        r.report_desc_len = 8'($urandom);
        r.mfr_chars       = 7'($urandom);
        r.prod_chars      = 7'($urandom);
        r.serial_chars    = 7'($urandom);
        return r;
    endfunction

    // Directed pass at reset register values: every request, both halt
    // transitions, recipients, clamp edges, strings, report types, bad types.
    task automatic directed_requests();
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_STATUS,
                             16'h0000, 16'h0002));
        send_setup(setup_pkt({1'b0, REQ_TYPE_STANDARD, RECIP_ENDPOINT}, REQ_SET_FEATURE,
                             16'h0000, 16'h0000));
        // status word reports halt only for the endpoint recipient
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_ENDPOINT}, REQ_GET_STATUS,
                             16'h0000, 16'h0000));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_INTERFACE}, REQ_GET_STATUS,
                             16'h0000, 16'hffff));
        // feature to a device recipient stalls, halt stays set
        send_setup(setup_pkt({1'b0, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_CLEAR_FEATURE,
                             16'h0000, 16'h0000));
        send_setup(setup_pkt({1'b0, REQ_TYPE_STANDARD, RECIP_ENDPOINT}, REQ_CLEAR_FEATURE,
                             16'h0000, 16'h0000));
        // only the low seven bits of the address are kept
        send_setup(setup_pkt({1'b0, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_ASSIGN_ADDR,
                             16'hffff, 16'h0000));
        send_setup(setup_pkt({1'b0, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_ASSIGN_ADDR,
                             16'h0005, 16'h0000));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_DEVICE, 8'h00}, 16'hffff));
        // wLength of 256: an 8-bit clamp would give zero here
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_DEVICE, 8'h00}, 16'h0100));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_DEVICE, 8'h00}, 16'h0008));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_CONFIG, 8'h00}, 16'h0000));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, STR_LANGUAGE}, 16'h00ff));
        // manufacturer, product and serial string descriptors ignore wLength
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, STR_MANUFACTURER}, 16'h0000));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, STR_PRODUCT}, 16'h0001));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, STR_SERIAL}, 16'hffff));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, STR_SERIAL + 8'd1}, 16'hffff));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_INTERFACE}, REQ_GET_DESCRIPTOR,
                             {DESC_HID_REPORT, 8'h00}, 16'hffff));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_INTERFACE, 8'h00}, 16'hffff));
        send_setup(setup_pkt({1'b0, REQ_TYPE_STANDARD, RECIP_DEVICE}, REQ_SET_CONFIGURATION,
                             16'h0001, 16'h0000));
        // HID report read: input gives data, output/feature stall, others give a no-change reply
        send_setup(setup_pkt({1'b1, REQ_TYPE_CLASS, RECIP_INTERFACE}, REQ_HID_READ_REPORT,
                             {REPORT_INPUT, 8'h00}, 16'h0010));
        send_setup(setup_pkt({1'b1, REQ_TYPE_CLASS, RECIP_INTERFACE}, REQ_HID_READ_REPORT,
                             {REPORT_OUTPUT, 8'h00}, 16'h0010));
        send_setup(setup_pkt({1'b1, REQ_TYPE_CLASS, RECIP_INTERFACE}, REQ_HID_READ_REPORT,
                             {REPORT_FEATURE, 8'h00}, 16'h0010));
        send_setup(setup_pkt({1'b1, REQ_TYPE_CLASS, RECIP_INTERFACE}, REQ_HID_READ_REPORT,
                             {REPORT_RSVD, 8'hff}, 16'h0010));
        // vendor, reserved and unknown requests all stall
        send_setup(setup_pkt({1'b1, REQ_TYPE_VENDOR, RECIP_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DESC_DEVICE, 8'h00}, 16'hffff));
        send_setup(setup_pkt({1'b1, REQ_TYPE_STANDARD, RECIP_ENDPOINT}, REQ_SYNCH_FRAME,
                             16'h0000, 16'h0002));
        send_setup(setup_pkt({1'b1, REQ_TYPE_RSVD, 5'h1f}, 8'hff, 16'hffff, 16'hffff));
        setup_bus.valid <= 1'b0;
    endtask

    // One random phase. squeeze_at >= 0 starts the long receiver hold-off
    // at that transaction while the sender keeps pushing.
    task automatic run_random(input int count, input int s_idle, input int r_idle,
                              input int squeeze_at);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++)
        begin
            if (i == squeeze_at)
                stall_req = 1'b1;
            send_setup(random_setup());
        end
        setup_bus.valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        setup_bus.valid <= 1'b0;
        setup_bus.data  <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.data    <= '0;
        live_regs = '{dev_desc_len: 8'd18, conf_total_len: 10'd34, lang_desc_len: 8'd4,
                      report_desc_len: 8'd52, mfr_chars: 7'd0, prod_chars: 7'd0,
                      serial_chars: 7'd0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass runs against the reset register values
        directed_requests();
        wait_drained();

        // largest lengths; a 127-character string must not wrap at 8 bits
        program_regs('{dev_desc_len: 8'd255, conf_total_len: 10'd1023,
                       lang_desc_len: 8'd255, report_desc_len: 8'd255,
                       mfr_chars: 7'd127, prod_chars: 7'd126, serial_chars: 7'd126});
        run_random(300, 9, 70, 120);

        // all-zero registers
        program_regs('0);
        run_random(300, 9, 70, -1);

        // sender now idles a lot, receiver rarely
        program_regs(random_regs());
        run_random(350, 70, 9, -1);
        program_regs(random_regs());
        run_random(350, 70, 9, -1);

        // back to back, with one more long hold-off in the middle
        program_regs(random_regs());
        run_random(650, 0, 0, 300);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
